// ----- sv/rlec_pkg.sv -----
// Shared types, constants and helper functions of the run-length escape compressor.
`timescale 1ns / 1ps
package rlec_pkg;

    localparam int BYTE_W             = 8;
    localparam int RUN_W              = 8;
    localparam int MIN_RUN_W          = 3;
    localparam int CNT3_W             = 3;
    localparam int MAX_RUN_DEFAULT    = 255;
    localparam int FIFO_DEPTH_DEFAULT = 4;
    localparam int CFG_IDX_W          = 1;

    localparam logic [BYTE_W-1:0]    ESCAPE_RESET  = 8'hFF;
    localparam logic [MIN_RUN_W-1:0] MIN_RUN_RESET = 3'd4;
    localparam logic [MIN_RUN_W-1:0] MIN_RUN_LOW   = 3'd1;
    localparam logic [MIN_RUN_W-1:0] MIN_RUN_HIGH  = 3'd4;
    localparam logic [BYTE_W-1:0]    ZERO_BYTE     = 8'h00;
    localparam logic [CNT3_W-1:0]    CODE_BYTES    = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPE  = 1'b0,
        CFG_MIN_RUN = 1'b1
    } cfg_idx_t;

    // Position codes inside a run code (escape, count, value)
    typedef enum logic [CNT3_W-1:0] {
        POS_ESC   = 3'd0,
        POS_COUNT = 3'd1,
        POS_VALUE = 3'd2
    } code_pos_t;

    // One queued command: up to two run flushes caused by one item
    typedef struct packed {
        logic              a_valid;
        logic [BYTE_W-1:0] a_value;
        logic [RUN_W-1:0]  a_len;
        logic              b_valid;
        logic [BYTE_W-1:0] b_value;
        logic [RUN_W-1:0]  b_len;
        logic              last;
    } rlec_cmd_t;

    function automatic logic [MIN_RUN_W-1:0] eff_min_run(input logic [MIN_RUN_W-1:0] m);
        logic [MIN_RUN_W-1:0] r;
        begin
            r = m;
            if (m < MIN_RUN_LOW)
                r = MIN_RUN_LOW;
            else if (m > MIN_RUN_HIGH)
                r = MIN_RUN_HIGH;
            return r;
        end
    endfunction

endpackage

// ----- sv/rlec_if.sv -----
// Valid/ready channel interfaces for raw input items and compressed result items.
`timescale 1ns / 1ps
interface rlec_in_if;
    import rlec_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rlec_out_if;
    import rlec_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic              stream_end;

    modport source (output valid, output out_byte, output out_last, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input stream_end,
                    output ready);
endinterface

// ----- sv/rle_escape_compressor_core.sv -----
// Top level of the escape-byte run-length compressor.
// Usage:
//   din takes one raw byte per item with in_last marking the stream's final byte.
//   dout gives compressed bytes; out_last marks the last byte caused by one input
//   item, stream_end the final byte of the stream. An item may cause 0 to 8 bytes.
//   cfg_we/cfg_index/cfg_data write the escape marker (index 0) and min_run
//   (index 1); write them only while the block is idle.
// Timing:
//   An input item is taken every cycle while the command queue has room.
//   The first byte of an item passes through the command queue and the output
//   register before it is driven on dout. The emitter drives one compressed byte
//   per cycle while dout is ready; items that only extend a run cause no bytes.
// Reset:
//   Clears the open run, the queue and the output valid flag; the escape marker
//   returns to 0xFF and min_run to 4.
// Backpressure:
//   When dout stalls the output register holds, the emitter waits, and the
//   queue fills; din.ready drops only once the queue is full.
`timescale 1ns / 1ps
module rle_escape_compressor_core
    import rlec_pkg::*;
#(
    parameter int MAX_RUN    = MAX_RUN_DEFAULT,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    rlec_in_if.sink              din,
    rlec_out_if.source           dout,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    logic [BYTE_W-1:0]    escape_reg;
    logic [MIN_RUN_W-1:0] min_run_reg;

    logic       push;
    rlec_cmd_t  push_data;
    logic       full;
    logic       pop;
    rlec_cmd_t  head;
    logic       not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg  <= ESCAPE_RESET;
            min_run_reg <= MIN_RUN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ESCAPE:  escape_reg  <= cfg_data;
                CFG_MIN_RUN: min_run_reg <= cfg_data[MIN_RUN_W-1:0];
                default:     ;
            endcase
        end
    end

    rlec_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    rlec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    rlec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .escape    (escape_reg),
        .min_run   (min_run_reg),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .dout      (dout)
    );

endmodule

// ----- sv/rlec_front.sv -----
// Front end: tracks the open run and queues flush commands per accepted item.
`timescale 1ns / 1ps
module rlec_front
    import rlec_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEFAULT
)(
    input  logic       clk,
    input  logic       rst_n,
    rlec_in_if.sink    din,
    input  logic       full,
    output logic       push,
    output rlec_cmd_t  push_data
);

    logic [BYTE_W-1:0] value_reg, value_next;
    logic [RUN_W-1:0]  len_reg, len_next;
    logic              accept;
    logic              flush_a;
    logic [BYTE_W-1:0] run_value;
    logic [RUN_W-1:0]  run_len;

    assign din.ready = !full;
    assign accept    = din.valid && din.ready;

    always_comb
    begin
        // Close the open run on a new byte or when it is already at the cap
        flush_a = (len_reg != '0) &&
                  ((din.in_byte != value_reg) || (len_reg >= RUN_W'(MAX_RUN)));
        if ((len_reg == '0) || flush_a)
        begin
            run_value = din.in_byte;
            run_len   = RUN_W'(1);
        end
        else
        begin
            run_value = value_reg;
            run_len   = len_reg + 1'b1;
        end

        push_data.a_valid = flush_a;
        push_data.a_value = value_reg;
        push_data.a_len   = len_reg;
        push_data.b_valid = din.in_last;
        push_data.b_value = run_value;
        push_data.b_len   = run_len;
        push_data.last    = din.in_last;
        push              = accept && (flush_a || din.in_last);

        value_next = value_reg;
        len_next   = len_reg;
        if (accept)
        begin
            if (din.in_last)
            begin
                value_next = ZERO_BYTE;
                len_next   = '0;
            end
            else
            begin
                value_next = run_value;
                len_next   = run_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            value_reg <= value_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- sv/rlec_fifo.sv -----
// Short command queue between the front end and the byte emitter.
`timescale 1ns / 1ps
module rlec_fifo
    import rlec_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEFAULT
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rlec_cmd_t  push_data,
    output logic       full,
    input  logic       pop,
    output rlec_cmd_t  head,
    output logic       not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rlec_cmd_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/rlec_back.sv -----
// Back end: expands queued flush commands into compressed bytes, one per cycle while dout is ready.
`timescale 1ns / 1ps
module rlec_back
    import rlec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BYTE_W-1:0]    escape,
    input  logic [MIN_RUN_W-1:0] min_run,
    input  rlec_cmd_t            head,
    input  logic                 not_empty,
    output logic                 pop,
    rlec_out_if.source           dout
);

    logic                 seg_reg, seg_next;
    logic [CNT3_W-1:0]    pos_reg, pos_next;
    logic                 valid_reg, valid_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic                 end_reg, end_next;

    logic                 step;
    logic                 sel_b;
    logic [BYTE_W-1:0]    seg_value;
    logic [RUN_W-1:0]     seg_len;
    logic [MIN_RUN_W-1:0] min_eff;
    logic                 is_code;
    logic                 is_esc;
    logic [CNT3_W-1:0]    seg_count;
    logic                 seg_done;
    logic                 cmd_done;
    logic [BYTE_W-1:0]    cur_byte;

    assign dout.valid      = valid_reg;
    assign dout.out_byte   = byte_reg;
    assign dout.out_last   = last_reg;
    assign dout.stream_end = end_reg;

    assign step = not_empty && (!valid_reg || dout.ready);

    always_comb
    begin
        // Skip the first flush when the command has none
        sel_b     = seg_reg || !head.a_valid;
        seg_value = sel_b ? head.b_value : head.a_value;
        seg_len   = sel_b ? head.b_len : head.a_len;
        min_eff   = eff_min_run(min_run);
        is_code   = (seg_len >= RUN_W'(min_eff));
        is_esc    = (seg_value == escape);

        // Literal runs are shorter than min_run, so at most three bytes long
        if (is_code)
            seg_count = CODE_BYTES;
        else if (is_esc)
            seg_count = {seg_len[1:0], 1'b0};
        else
            seg_count = {1'b0, seg_len[1:0]};

        if (is_code)
        begin
            case (code_pos_t'(pos_reg))
                POS_ESC:   cur_byte = escape;
                POS_COUNT: cur_byte = seg_len;
                default:   cur_byte = seg_value;
            endcase
        end
        else if (is_esc)
            cur_byte = pos_reg[0] ? ZERO_BYTE : escape;
        else
            cur_byte = seg_value;

        seg_done = (pos_reg == seg_count - 1'b1);
        cmd_done = seg_done && (sel_b || !head.b_valid);
        pop      = step && cmd_done;

        seg_next   = seg_reg;
        pos_next   = pos_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        end_next   = end_reg;

        if (valid_reg && dout.ready)
            valid_next = 1'b0;

        if (step)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            last_next  = cmd_done;
            end_next   = cmd_done && head.last;
            if (cmd_done)
            begin
                seg_next = 1'b0;
                pos_next = '0;
            end
            else if (seg_done)
            begin
                seg_next = 1'b1;
                pos_next = '0;
            end
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg   <= 1'b0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg   <= seg_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

endmodule
